// File: src/bvs_pkg.sv
// Package for the bounded vector store: field widths, command and status codes,
// and the control struct broadcast to the storage cells. No dependencies.
package bvs_pkg;

   localparam int DATA_BITS  = 32;
   localparam int INDEX_BITS = 4;
   localparam int COUNT_BITS = 5;
   localparam int CAP_BITS   = 5;
   localparam int CMD_BITS   = 2;
   localparam int STAT_BITS  = 2;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_PUSH   = 2'd1,
      CMD_GET    = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_NO_ENTRY = 2'd2
   } status_type;

   typedef struct packed {
      logic                  do_push;
      logic                  do_remove;
      logic [INDEX_BITS-1:0] index;
      logic [COUNT_BITS-1:0] count;
      logic [DATA_BITS-1:0]  push_data;
   } cell_ctl_type;

endpackage

// File: src/bvs_cell.sv
// One storage cell of the vector: holds a single element and either loads a
// pushed value or takes its right neighbor's value on a remove. Uses bvs_pkg.
module bvs_cell
   import bvs_pkg::*;
#(
   parameter int POS  = 0,
   parameter int BITS = 32
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [BITS-1:0]  right_data,
   output logic [BITS-1:0]  data
);

   logic [BITS-1:0] data_ff;
   logic [BITS-1:0] data_in;
   logic            load;
   logic            shift;

   // A push lands in the cell that sits at the current count; a remove pulls
   // the cells above the index, up to the last held one, one place down.
   assign load  = ctl.do_push && (POS == 32'(ctl.count));
   assign shift = ctl.do_remove && (POS >= 32'(ctl.index)) && ((POS + 1) < 32'(ctl.count));

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = ctl.push_data[BITS-1:0];
      end else if (shift) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: src/bounded_vector_store_top.sv
// Bounded vector store: a fixed-capacity packed vector held in a row of cells.
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while no result is stalled; count_ff feeds back.
// Reset (synchronous): count cleared, capacity back to 16, no result pending.
// Element cells are not reset; they are only ever read after being written.
// Depends on bvs_pkg and bvs_cell.
module bounded_vector_store_top
   import bvs_pkg::*;
#(
   parameter int DEPTH        = 16,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_BITS-1:0]   req_command,
   input  logic [INDEX_BITS-1:0] req_index,
   input  logic [DATA_BITS-1:0]  req_element_data,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_BITS-1:0]  rsp_status,
   output logic [DATA_BITS-1:0]  rsp_read_data,
   output logic [COUNT_BITS-1:0] rsp_element_count,
   // Configuration port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [1:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // Only the low bits of an element survive: the request field is 32 bits wide.
   localparam int STORE_BITS = (ELEMENT_BITS < DATA_BITS) ? ELEMENT_BITS : DATA_BITS;
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Configuration register. There is a single register, so every address maps to it.
   logic [CAP_BITS-1:0] cap_ff;
   logic                cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = 32'(cap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (cfg_write) begin
         cap_ff <= pwdata[CAP_BITS-1:0];
      end
   end

   // Element count and result register.
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            status_ff;
   status_type            status_in;
   logic [DATA_BITS-1:0]  read_data_ff;
   logic [DATA_BITS-1:0]  read_data_in;

   logic                  accept;
   cmd_type               cmd;
   logic [COUNT_BITS-1:0] usable_cap;
   logic                  index_held;
   logic                  room_left;
   cell_ctl_type          ctl;

   // A new request is taken whenever the result register is empty or is
   // being drained in the same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);

   // Capacity values beyond the built depth act as the depth itself.
   assign usable_cap = (32'(cap_ff) > DEPTH) ? COUNT_BITS'(DEPTH) : COUNT_BITS'(cap_ff);
   assign room_left  = (count_ff < usable_cap) && (32'(count_ff) < DEPTH);
   assign index_held = (COUNT_BITS'(req_index) < count_ff) && (32'(req_index) < DEPTH);

   // The row of cells. Each cell sees the same broadcast control and its
   // right neighbor's value; the last cell never shifts, so its input is tied off.
   logic [STORE_BITS-1:0] cell_data [DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [STORE_BITS-1:0] right_val;
         if (gi < DEPTH - 1) begin : g_inner
            assign right_val = cell_data[gi + 1];
         end else begin : g_last
            assign right_val = '0;
         end
         bvs_cell #(
            .POS  (gi),
            .BITS (STORE_BITS)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .right_data (right_val),
            .data       (cell_data[gi])
         );
      end
   endgenerate

   // Command decode: status, read data and the new count for this request.
   always_comb begin
      count_in     = count_ff;
      status_in    = ST_OK;
      read_data_in = '0;
      ctl          = '0;
      ctl.index    = req_index;
      ctl.count    = count_ff;
      ctl.push_data = req_element_data;
      case (cmd)
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_PUSH: begin
            if (room_left) begin
               ctl.do_push = 1'b1;
               count_in    = count_ff + COUNT_BITS'(1);
            end else begin
               status_in = ST_NO_SPACE;
            end
         end
         CMD_GET: begin
            if (index_held) begin
               read_data_in = DATA_BITS'(cell_data[IDX_BITS'(req_index)]);
            end else begin
               status_in = ST_NO_ENTRY;
            end
         end
         CMD_REMOVE: begin
            if (index_held) begin
               ctl.do_remove = 1'b1;
               count_in      = count_ff - COUNT_BITS'(1);
            end else begin
               status_in = ST_NO_ENTRY;
            end
         end
         default: begin
            status_in = ST_NO_ENTRY;
         end
      endcase
      // Nothing moves unless the request is actually taken.
      if (!accept) begin
         ctl.do_push   = 1'b0;
         ctl.do_remove = 1'b0;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         read_data_ff <= read_data_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_read_data     = read_data_ff;
   assign rsp_element_count = count_ff;

   // The count never runs past the built depth.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("element count exceeds the built depth");

   // A successful push grows the count by exactly one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_PUSH && status_in == ST_OK)
      |=> (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("push did not advance the count");

   // A failed request never returns data.
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_OK) |-> (read_data_ff == '0))
      else $error("failed request returned nonzero data");

   // A result that waits is not disturbed by a new request.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(count_ff)))
      else $error("stalled result was disturbed");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for bounded_vector_store_top: directed and random clear,
// push, get and remove requests are checked against a behavioral mirror of the vector.
// Depends on bvs_pkg and the RTL of the block; reads no files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bvs_pkg::*;

   // The block is built at its default size. The capacity register is register 0.
   localparam int SLOTS        = 16;
   localparam int CAPACITY_REG = 0;
   localparam int CYCLE_LIMIT  = 400000;

   // One answer the block owes for an accepted request.
   typedef struct {
      status_type            status;
      logic [DATA_BITS-1:0]  read_data;
      logic [COUNT_BITS-1:0] count;
   } vector_answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_BITS-1:0]   req_command = '0;
   logic [INDEX_BITS-1:0] req_index = '0;
   logic [DATA_BITS-1:0]  req_element_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STAT_BITS-1:0]  rsp_status;
   logic [DATA_BITS-1:0]  rsp_read_data;
   logic [COUNT_BITS-1:0] rsp_element_count;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [1:0]            paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Mirror of the vector: its elements, its count and the capacity register.
   logic [DATA_BITS-1:0]  mirror_elems [SLOTS];
   int                    mirror_count = 0;
   logic [CAP_BITS-1:0]   mirror_capacity = CAP_RESET;

   vector_answer_type     owed_answers [$];
   int                    mismatches = 0;
   int                    cycle_count = 0;
   // When set, neither side inserts idle cycles, so requests go back to back.
   bit                    quiet = 1'b0;
   int                    stall_left = 0;

   bounded_vector_store_top #(
      .DEPTH       (SLOTS),
      .ELEMENT_BITS(DATA_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_index        (req_index),
      .req_element_data (req_element_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .rsp_element_count(rsp_element_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #4 clock = ~clock;

   // Watchdog: a correct run finishes far below this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Every mismatch goes through here: one line, one count.
   task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("ERROR at %0t ns: %s is %h, expected %h", $time, what, got, want);
   endtask

   // Applies one accepted request to the mirror and queues the answer it owes.
   // A push beyond the usable capacity fails, and the usable capacity is the
   // register value clipped to the built depth. Failed commands leave the
   // mirror untouched and answer zero read data.
   function automatic void apply_to_mirror(cmd_type cmd, logic [INDEX_BITS-1:0] idx,
                                           logic [DATA_BITS-1:0] data);
      vector_answer_type ans;
      int                usable;
      ans.status    = ST_OK;
      ans.read_data = '0;
      usable = (mirror_capacity > SLOTS) ? SLOTS : int'(mirror_capacity);
      case (cmd)
         CMD_CLEAR: begin
            mirror_count = 0;
         end
         CMD_PUSH: begin
            if (mirror_count >= usable) begin
               ans.status = ST_NO_SPACE;
            end else begin
               mirror_elems[mirror_count] = data;
               mirror_count++;
            end
         end
         CMD_GET: begin
            if (int'(idx) >= mirror_count) ans.status = ST_NO_ENTRY;
            else ans.read_data = mirror_elems[idx];
         end
         default: begin
            // Remove closes the gap by moving every later element down one slot.
            if (int'(idx) >= mirror_count) begin
               ans.status = ST_NO_ENTRY;
            end else begin
               for (int k = int'(idx); k + 1 < mirror_count; k++)
                  mirror_elems[k] = mirror_elems[k + 1];
               mirror_count--;
            end
         end
      endcase
      ans.count = COUNT_BITS'(mirror_count);
      owed_answers.push_back(ans);
   endfunction

   // Result side. Each result accepted at this edge is compared with the oldest
   // owed answer. After each accepted result the receiver draws a random stall
   // (none when quiet), so ready drops at changing points of the block's work.
   always @(posedge clock) begin
      vector_answer_type ans;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_answers.size() == 0) begin
            note_mismatch("unexpected result, status", 32'(rsp_status), 32'hx);
         end else begin
            ans = owed_answers.pop_front();
            if (rsp_status !== ans.status)
               note_mismatch("status", 32'(rsp_status), 32'(ans.status));
            if (rsp_read_data !== ans.read_data)
               note_mismatch("read data", rsp_read_data, ans.read_data);
            if (rsp_element_count !== ans.count)
               note_mismatch("element count", 32'(rsp_element_count), 32'(ans.count));
         end
         stall_left = quiet ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Sends one request. It is entered at a rising edge and returns at the edge
   // at which the request was accepted. Valid is only lowered when a gap
   // follows, so back-to-back requests keep valid high without a glitch.
   task automatic send_request(cmd_type cmd, logic [INDEX_BITS-1:0] idx,
                               logic [DATA_BITS-1:0] data);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_index        <= idx;
      req_element_data <= data;
      do @(posedge clock); while (!req_ready);
      apply_to_mirror(cmd, idx, data);
   endtask

   // Stops sending and waits until every owed answer has arrived, then lets
   // the block settle with some margin.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (owed_answers.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes the capacity register with random upper bits in the write data,
   // then reads it back. The write lands at the edge that ends the access
   // phase; the read setup follows in the same step without releasing psel.
   task automatic set_capacity(logic [CAP_BITS-1:0] value);
      logic [31:0] word;
      wait_until_idle();
      word = $urandom();
      word[CAP_BITS-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 2'(4 * CAPACITY_REG);
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      mirror_capacity = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[CAP_BITS-1:0] !== mirror_capacity)
         note_mismatch("capacity read back", 32'(prdata[CAP_BITS-1:0]),
                       32'(mirror_capacity));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Empty vector after reset, data extremes, the top index, removal from the
   // front with the shift, and a clear carrying junk in its unused fields.
   task automatic test_basic_commands();
      send_request(CMD_GET, 4'd0, $urandom());
      send_request(CMD_REMOVE, 4'd15, $urandom());
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), 32'h0000_0000);
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), 32'hFFFF_FFFF);
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), 32'hA5A5_5A5A);
      send_request(CMD_GET, 4'd15, $urandom());
      send_request(CMD_GET, 4'd2, $urandom());
      send_request(CMD_REMOVE, 4'd0, $urandom());
      send_request(CMD_GET, 4'd0, $urandom());
      send_request(CMD_CLEAR, INDEX_BITS'($urandom()), $urandom());
      send_request(CMD_GET, 4'd0, $urandom());
   endtask

   // Capacity zero refuses every push, capacity one takes a single element,
   // a value above the depth acts as the depth, and a capacity lowered below
   // the count keeps the held elements readable and removable while pushes
   // fail until the count falls below it.
   task automatic test_capacity_limits();
      set_capacity(5'd0);
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
      set_capacity(5'd1);
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
      set_capacity(5'd31);
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
      set_capacity(5'd2);
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
      send_request(CMD_GET, 4'd2, $urandom());
      send_request(CMD_REMOVE, 4'd2, $urandom());
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
      send_request(CMD_REMOVE, 4'd0, $urandom());
      send_request(CMD_PUSH, INDEX_BITS'($urandom()), $urandom());
   endtask

   // Random traffic in phases, each under its own capacity. Within a phase the
   // mix swings between filling (mostly pushes) and draining (mostly gets and
   // removes) so the vector runs full and empty repeatedly. Most indexes hit a
   // held element; the rest are drawn over the whole field.
   task automatic test_random_traffic();
      logic [CAP_BITS-1:0]   phase_caps [8];
      int                    push_pct;
      int                    pick;
      cmd_type               cmd;
      logic [INDEX_BITS-1:0] idx;
      phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd2, 5'd8, 5'd16};
      phase_caps[6] = CAP_BITS'($urandom_range(0, 31));
      for (int phase = 0; phase < 8; phase++) begin
         set_capacity(phase_caps[phase]);
         quiet = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 205; n++) begin
            push_pct = ((n / 40) % 2 == 0) ? 75 : 15;
            pick = $urandom_range(0, 99);
            if (pick < 3) cmd = CMD_CLEAR;
            else if (pick < 3 + push_pct) cmd = CMD_PUSH;
            else if (pick % 2 == 0) cmd = CMD_GET;
            else cmd = CMD_REMOVE;
            if (mirror_count > 0 && $urandom_range(0, 4) != 0)
               idx = INDEX_BITS'($urandom_range(0, mirror_count - 1));
            else
               idx = INDEX_BITS'($urandom_range(0, 15));
            // Flip quiet mid-phase: bursts in gappy phases, gaps in quiet ones.
            if (n % 50 == 25) quiet = ~quiet;
            send_request(cmd, idx, $urandom());
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_basic_commands();
      test_capacity_limits();
      test_random_traffic();
      wait_until_idle();
      if (mismatches == 0 && owed_answers.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
